>>> rtl/srsp_pkg.sv
// Package for the status reply stream parser: parser phase enum, result item
// record, result kinds and the key words scanned for. No dependencies.
package srsp_pkg;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_DROP1,
      PH_LEN1,
      PH_DROP2,
      PH_LEN2,
      PH_SCAN,
      PH_COLON_NUM,
      PH_NUM,
      PH_COLON_DESC,
      PH_QUOTE_DESC,
      PH_DESC
   } phase_type;

   typedef enum logic [1:0] {
      KEY_ONLINE,
      KEY_MAX,
      KEY_DESC
   } key_sel_type;

   localparam logic [2:0] KIND_ONLINE    = 3'd0;
   localparam logic [2:0] KIND_MAX       = 3'd1;
   localparam logic [2:0] KIND_DESC_CHAR = 3'd2;
   localparam logic [2:0] KIND_DESC_END  = 3'd3;
   localparam logic [2:0] KIND_REPLY_END = 3'd4;

   localparam logic [1:0] STATUS_ONLINE    = 2'd0;
   localparam logic [1:0] STATUS_NO_ONLINE = 2'd1;
   localparam logic [1:0] STATUS_SHORT     = 2'd2;

   localparam int          ONLINE_LEN    = 6;
   localparam int          MAX_LEN       = 3;
   localparam int          DESC_LEN      = 11;
   localparam int          MIN_REPLY_LEN = 10;
   localparam logic [30:0] COUNT_MAX     = 31'h7FFF_FFFF;
   localparam logic [7:0]  CHAR_QUOTE    = 8'h22;
   localparam logic [7:0]  CHAR_ZERO     = 8'h30;
   localparam logic [7:0]  CHAR_NINE     = 8'h39;

   localparam int FIFO_DEPTH = 4;

   typedef struct packed {
      logic [2:0]  kind;
      logic [30:0] value;
      logic [1:0]  status;
      logic        last;
   } result_type;

   function automatic logic [7:0] key_char(key_sel_type sel, logic [3:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      unique case (sel)
         KEY_ONLINE: begin
            unique case (idx)
               4'd0: ch = "o";
               4'd1: ch = "n";
               4'd2: ch = "l";
               4'd3: ch = "i";
               4'd4: ch = "n";
               4'd5: ch = "e";
               default: ch = 8'h00;
            endcase
         end
         KEY_MAX: begin
            unique case (idx)
               4'd0: ch = "m";
               4'd1: ch = "a";
               4'd2: ch = "x";
               default: ch = 8'h00;
            endcase
         end
         KEY_DESC: begin
            unique case (idx)
               4'd0:  ch = "d";
               4'd1:  ch = "e";
               4'd2:  ch = "s";
               4'd3:  ch = "c";
               4'd4:  ch = "r";
               4'd5:  ch = "i";
               4'd6:  ch = "p";
               4'd7:  ch = "t";
               4'd8:  ch = "i";
               4'd9:  ch = "o";
               4'd10: ch = "n";
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

>>> rtl/status_reply_stream_parser.sv
// Status reply stream parser, top level. One received byte per item; each
// item's state update and results come from one pass of logic. Uses srsp_pkg.
//
// The parser takes one item per clock while req_ready is high: a start
// (action 0) or one reply byte. It skips a byte, decodes a 7-bit-group length,
// rejects replies shorter than 10, skips a byte, decodes the body length and
// scans the body for the keys online, max and description. Results (counts,
// description characters, description end, reply end) leave through a 4-entry
// result queue, one per clock while rsp_ready is high, from the cycle after the
// item that causes them. req_ready drops while fewer than two queue entries are
// free. An item gives at most two results, and two only when it ends a reply,
// after which only zero-result items follow until the next reply is under way;
// so while the result side holds rsp_ready high the queue never holds more than
// two and the block takes one item every cycle. It stalls only when the result
// side holds rsp_ready low. Keys are matched on the fly, so no key bytes are
// stored; KEY_DEPTH sets where a long key wraps.
module status_reply_stream_parser
   import srsp_pkg::*;
#(
   parameter int KEY_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [30:0] rsp_value,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   localparam int KLW = $clog2(KEY_DEPTH + 1);
   localparam int PW  = $clog2(FIFO_DEPTH);
   localparam int CW  = $clog2(FIFO_DEPTH + 1);

   phase_type       phase_ff, phase_in;
   logic [31:0]     length_accum_ff, length_accum_in;
   logic [2:0]      group_count_ff, group_count_in;
   logic [31:0]     body_length_ff, body_length_in;
   logic [31:0]     consumed_count_ff, consumed_count_in;
   logic [KLW-1:0]  key_length_ff, key_length_in;
   logic [30:0]     number_accum_ff, number_accum_in;
   logic            number_target_ff, number_target_in;
   logic            got_online_ff, got_online_in;
   logic [2:0]      match_ff, match_in;

   result_type      fifo_mem_ff [FIFO_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   logic            accept;
   logic            pop;
   logic [7:0]      c;

   // length decoding
   logic [31:0]     lb_shifted;
   logic [31:0]     lb_acc;
   logic [2:0]      lb_gc;
   logic            lb_done;

   // numbers
   logic [34:0]     num_prod;
   logic [30:0]     num_next;
   logic            is_digit;

   // results
   logic            res_a_en, res_end_en;
   result_type      res_a, res_end;
   result_type      res0, res1;
   logic [1:0]      res_n;

   logic            key_first;
   logic [KLW-1:0]  online_len, max_len, desc_len;

   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign c         = req_rx_byte;
   assign req_ready = (count_ff <= CW'(FIFO_DEPTH - 2));

   assign online_len = KLW'(ONLINE_LEN);
   assign max_len    = KLW'(MAX_LEN);
   assign desc_len   = KLW'(DESC_LEN);

   always_comb begin
      unique case (group_count_ff)
         3'd0:    lb_shifted = {25'd0, c[6:0]};
         3'd1:    lb_shifted = {18'd0, c[6:0], 7'd0};
         3'd2:    lb_shifted = {11'd0, c[6:0], 14'd0};
         3'd3:    lb_shifted = {4'd0, c[6:0], 21'd0};
         3'd4:    lb_shifted = {c[3:0], 28'd0};
         default: lb_shifted = 32'd0;
      endcase
      lb_gc   = group_count_ff;
      lb_acc  = length_accum_ff;
      lb_done = 1'b0;
      if (c == 8'h00) begin
         lb_acc  = 32'd0;
         lb_done = 1'b1;
      end else begin
         lb_gc = group_count_ff + 3'd1;
         if (lb_gc > 3'd5) begin
            lb_acc  = 32'd0;
            lb_done = 1'b1;
         end else begin
            lb_acc  = length_accum_ff | lb_shifted;
            lb_done = !c[7];
         end
      end
   end

   always_comb begin
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      num_prod = ({4'd0, number_accum_ff} << 3) + ({4'd0, number_accum_ff} << 1)
                 + {31'd0, c[3:0]};
      num_next = (num_prod > {4'd0, COUNT_MAX}) ? COUNT_MAX : num_prod[30:0];
   end

   always_comb begin
      phase_in          = phase_ff;
      length_accum_in   = length_accum_ff;
      group_count_in    = group_count_ff;
      body_length_in    = body_length_ff;
      consumed_count_in = consumed_count_ff;
      key_length_in     = key_length_ff;
      number_accum_in   = number_accum_ff;
      number_target_in  = number_target_ff;
      got_online_in     = got_online_ff;
      match_in          = match_ff;
      res_a_en          = 1'b0;
      res_end_en        = 1'b0;
      res_a             = '0;
      res_end           = '0;
      res_end.kind      = KIND_REPLY_END;
      key_first         = (key_length_ff == '0);

      if (accept) begin
         if (!req_action) begin
            phase_in          = PH_DROP1;
            length_accum_in   = 32'd0;
            group_count_in    = 3'd0;
            body_length_in    = 32'd0;
            consumed_count_in = 32'd0;
            key_length_in     = '0;
            number_accum_in   = 31'd0;
            number_target_in  = 1'b0;
            got_online_in     = 1'b0;
            match_in          = 3'b000;
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
               end
               PH_DROP1: phase_in = PH_LEN1;
               PH_LEN1: begin
                  length_accum_in = lb_acc;
                  group_count_in  = lb_gc;
                  if (lb_done) begin
                     if (lb_acc[31] || lb_acc < 32'(MIN_REPLY_LEN)) begin
                        res_end_en     = 1'b1;
                        res_end.status = STATUS_SHORT;
                        phase_in       = PH_IDLE;
                     end else begin
                        phase_in = PH_DROP2;
                     end
                     length_accum_in = 32'd0;
                     group_count_in  = 3'd0;
                  end
               end
               PH_DROP2: phase_in = PH_LEN2;
               PH_LEN2: begin
                  length_accum_in = lb_acc;
                  group_count_in  = lb_gc;
                  if (lb_done) begin
                     body_length_in    = lb_acc;
                     consumed_count_in = 32'd0;
                     key_length_in     = '0;
                     if (lb_acc[31] || lb_acc == 32'd0) begin
                        res_end_en     = 1'b1;
                        res_end.status = got_online_ff ? STATUS_ONLINE : STATUS_NO_ONLINE;
                        phase_in       = PH_IDLE;
                     end else begin
                        phase_in = PH_SCAN;
                     end
                  end
               end
               PH_SCAN, PH_COLON_NUM, PH_NUM, PH_COLON_DESC, PH_QUOTE_DESC,
               PH_DESC: begin
                  consumed_count_in = consumed_count_ff + 32'd1;
                  unique case (phase_ff)
                     PH_SCAN: begin
                        if (c == CHAR_QUOTE) begin
                           if (key_length_ff == online_len && match_ff[KEY_ONLINE]) begin
                              number_target_in = 1'b0;
                              phase_in         = PH_COLON_NUM;
                           end else if (key_length_ff == max_len && match_ff[KEY_MAX]) begin
                              number_target_in = 1'b1;
                              phase_in         = PH_COLON_NUM;
                           end else if (key_length_ff == desc_len
                                        && match_ff[KEY_DESC]) begin
                              phase_in = PH_COLON_DESC;
                           end
                           key_length_in = '0;
                        end else if (key_length_ff >= KLW'(KEY_DEPTH)) begin
                           key_length_in = '0;
                        end else begin
                           match_in[KEY_ONLINE] = (key_first || match_ff[KEY_ONLINE])
                              && (key_length_ff < online_len)
                              && (c == key_char(KEY_ONLINE, key_length_ff[3:0]));
                           match_in[KEY_MAX] = (key_first || match_ff[KEY_MAX])
                              && (key_length_ff < max_len)
                              && (c == key_char(KEY_MAX, key_length_ff[3:0]));
                           match_in[KEY_DESC] = (key_first || match_ff[KEY_DESC])
                              && (key_length_ff < desc_len)
                              && (c == key_char(KEY_DESC, key_length_ff[3:0]));
                           key_length_in = key_length_ff + KLW'(1);
                        end
                     end
                     PH_COLON_NUM: begin
                        number_accum_in = 31'd0;
                        phase_in        = PH_NUM;
                     end
                     PH_NUM: begin
                        if (is_digit) begin
                           number_accum_in = num_next;
                        end else begin
                           res_a_en        = 1'b1;
                           res_a.kind      = number_target_ff ? KIND_MAX : KIND_ONLINE;
                           res_a.value     = number_accum_ff;
                           if (!number_target_ff) begin
                              got_online_in = 1'b1;
                           end
                           number_accum_in = 31'd0;
                           phase_in        = PH_SCAN;
                        end
                     end
                     PH_COLON_DESC: phase_in = PH_QUOTE_DESC;
                     PH_QUOTE_DESC: phase_in = PH_DESC;
                     PH_DESC: begin
                        res_a_en = 1'b1;
                        if (c == 8'h00 || c == CHAR_QUOTE) begin
                           res_a.kind = KIND_DESC_END;
                           phase_in   = PH_SCAN;
                        end else begin
                           res_a.kind  = KIND_DESC_CHAR;
                           res_a.value = {23'd0, c};
                        end
                     end
                     default: begin
                     end
                  endcase
                  if (phase_in == PH_SCAN && consumed_count_in >= body_length_ff) begin
                     res_end_en     = 1'b1;
                     res_end.status = got_online_in ? STATUS_ONLINE : STATUS_NO_ONLINE;
                     phase_in       = PH_IDLE;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      res0 = res_a;
      res1 = res_end;
      res0.last = 1'b0;
      res1.last = 1'b1;
      res_n = 2'd0;
      if (res_a_en && res_end_en) begin
         res_n = 2'd2;
      end else if (res_a_en) begin
         res0.last = 1'b1;
         res_n     = 2'd1;
      end else if (res_end_en) begin
         res0  = res1;
         res_n = 2'd1;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(res_n);
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(res_n) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         length_accum_ff   <= 32'd0;
         group_count_ff    <= 3'd0;
         body_length_ff    <= 32'd0;
         consumed_count_ff <= 32'd0;
         key_length_ff     <= '0;
         number_accum_ff   <= 31'd0;
         number_target_ff  <= 1'b0;
         got_online_ff     <= 1'b0;
         match_ff          <= 3'b000;
         wr_ptr_ff         <= '0;
         rd_ptr_ff         <= '0;
         count_ff          <= '0;
      end else begin
         phase_ff          <= phase_in;
         length_accum_ff   <= length_accum_in;
         group_count_ff    <= group_count_in;
         body_length_ff    <= body_length_in;
         consumed_count_ff <= consumed_count_in;
         key_length_ff     <= key_length_in;
         number_accum_ff   <= number_accum_in;
         number_target_ff  <= number_target_in;
         got_online_ff     <= got_online_in;
         match_ff          <= match_in;
         wr_ptr_ff         <= wr_ptr_in;
         rd_ptr_ff         <= rd_ptr_in;
         count_ff          <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_n != 2'd0) begin
         fifo_mem_ff[wr_ptr_ff] <= res0;
      end
      if (res_n == 2'd2) begin
         fifo_mem_ff[wr_ptr_ff + PW'(1)] <= res1;
      end
   end

   assign rsp_valid  = (count_ff != '0);
   assign rsp_kind   = fifo_mem_ff[rd_ptr_ff].kind;
   assign rsp_value  = fifo_mem_ff[rd_ptr_ff].value;
   assign rsp_status = fifo_mem_ff[rd_ptr_ff].status;
   assign rsp_last   = fifo_mem_ff[rd_ptr_ff].last;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_REPLY_END |-> rsp_last)
      else $error("reply end not marked last");

   a_status_only_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_REPLY_END |-> rsp_status == STATUS_ONLINE)
      else $error("status set on non-end item");

   a_two_results_pair: assert property (@(posedge clock) disable iff (reset)
      res_n == 2'd2 |-> res_end_en && (res_a.kind == KIND_ONLINE
         || res_a.kind == KIND_MAX || res_a.kind == KIND_DESC_END))
      else $error("bad result pair");

   a_start_rearms: assert property (@(posedge clock) disable iff (reset)
      accept && !req_action |=> phase_ff == PH_DROP1 && key_length_ff == '0
         && !got_online_ff)
      else $error("start did not rearm parser");

endmodule

>>> bench/status_reply_stream_parser_tb.sv
// Testbench for status_reply_stream_parser: feeds directed and random status
// replies, predicts every result item and checks it as it leaves the block.
// Depends on rtl/srsp_pkg.sv and rtl/status_reply_stream_parser.sv.
`timescale 1ns / 100ps

module status_reply_stream_parser_tb
   import srsp_pkg::*;
;

   localparam int          KEY_DEPTH    = 32;
   localparam int          ITEM_TARGET  = 1200;
   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          DRAIN_CYCLES = 40;
   localparam logic        ACT_START    = 1'b0;
   localparam logic        ACT_BYTE     = 1'b1;
   localparam logic [1:0]  STATUS_NONE  = 2'd0;

   typedef struct packed {
      logic       act;
      logic [7:0] data;
   } rx_item_type;

   class reply_scoreboard;
      phase_type   phase;
      logic [31:0] len_acc, body_len, consumed;
      int          groups, key_len;
      logic [7:0]  key_buf [KEY_DEPTH];
      logic [30:0] count_acc;
      logic        count_is_max, got_online;
      result_type  awaited[$];
      int          mismatches, parsed_items;

      function new();
         phase = PH_IDLE;
         clear_parse();
         mismatches = 0;
         parsed_items = 0;
      endfunction

      function void clear_parse();
         len_acc = '0;
         groups = 0;
         body_len = '0;
         consumed = '0;
         key_len = 0;
         count_acc = '0;
         count_is_max = 1'b0;
         got_online = 1'b0;
      endfunction

      function void expect_result(logic [2:0] kind, logic [30:0] value, logic [1:0] status);
         result_type r;
         r.kind = kind;
         r.value = value;
         r.status = status;
         r.last = 1'b0;
         awaited.push_back(r);
      endfunction

      // one 7-bit group; returns 1 once the length is complete
      function bit take_length_byte(logic [7:0] c);
         if (c == 8'h00) begin
            len_acc = '0;
            return 1'b1;
         end
         if (groups < 5) len_acc |= {25'd0, c[6:0]} << (7 * groups);
         groups++;
         if (groups > 5) begin
            len_acc = '0;
            return 1'b1;
         end
         return !c[7];
      endfunction

      function bit key_is(string w);
         if (key_len != w.len()) return 1'b0;
         for (int i = 0; i < key_len; i++)
            if (key_buf[i] != w[i]) return 1'b0;
         return 1'b1;
      endfunction

      function void note_item(logic act, logic [7:0] c);
         int          before_n;
         result_type  r;
         logic [34:0] grown;
         before_n = awaited.size();
         if (act == ACT_START) begin
            clear_parse();
            phase = PH_DROP1;
            parsed_items++;
            return;
         end
         if (phase != PH_IDLE) parsed_items++;
         case (phase)
            PH_IDLE: ;
            PH_DROP1: phase = PH_LEN1;
            PH_LEN1: begin
               if (take_length_byte(c)) begin
                  if (len_acc[31] || len_acc < MIN_REPLY_LEN) begin
                     expect_result(KIND_REPLY_END, '0, STATUS_SHORT);
                     phase = PH_IDLE;
                  end else begin
                     phase = PH_DROP2;
                  end
                  len_acc = '0;
                  groups = 0;
               end
            end
            PH_DROP2: phase = PH_LEN2;
            PH_LEN2: begin
               if (take_length_byte(c)) begin
                  body_len = len_acc;
                  consumed = '0;
                  key_len = 0;
                  if (body_len[31] || body_len == 0) begin
                     expect_result(KIND_REPLY_END, '0,
                                   got_online ? STATUS_ONLINE : STATUS_NO_ONLINE);
                     phase = PH_IDLE;
                  end else begin
                     phase = PH_SCAN;
                  end
               end
            end
            default: begin
               consumed++;
               case (phase)
                  PH_SCAN: begin
                     if (c == CHAR_QUOTE) begin
                        if (key_is("online")) begin
                           count_is_max = 1'b0;
                           phase = PH_COLON_NUM;
                        end else if (key_is("max")) begin
                           count_is_max = 1'b1;
                           phase = PH_COLON_NUM;
                        end else if (key_is("description")) begin
                           phase = PH_COLON_DESC;
                        end
                        key_len = 0;
                     end else if (key_len >= KEY_DEPTH) begin
                        key_len = 0;
                     end else begin
                        key_buf[key_len] = c;
                        key_len++;
                     end
                  end
                  PH_COLON_NUM: begin
                     count_acc = '0;
                     phase = PH_NUM;
                  end
                  PH_NUM: begin
                     if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                        grown = count_acc * 35'd10 + (c - CHAR_ZERO);
                        count_acc = (grown > COUNT_MAX) ? COUNT_MAX : grown[30:0];
                     end else begin
                        expect_result(count_is_max ? KIND_MAX : KIND_ONLINE, count_acc,
                                      STATUS_NONE);
                        if (!count_is_max) got_online = 1'b1;
                        count_acc = '0;
                        phase = PH_SCAN;
                     end
                  end
                  PH_COLON_DESC: phase = PH_QUOTE_DESC;
                  PH_QUOTE_DESC: phase = PH_DESC;
                  default: begin
                     if (c == 8'h00 || c == CHAR_QUOTE) begin
                        expect_result(KIND_DESC_END, '0, STATUS_NONE);
                        phase = PH_SCAN;
                     end else begin
                        expect_result(KIND_DESC_CHAR, {23'd0, c}, STATUS_NONE);
                     end
                  end
               endcase
               // body limit only applies between keys
               if (phase == PH_SCAN && consumed >= body_len) begin
                  expect_result(KIND_REPLY_END, '0,
                                got_online ? STATUS_ONLINE : STATUS_NO_ONLINE);
                  phase = PH_IDLE;
               end
            end
         endcase
         if (awaited.size() > before_n) begin
            r = awaited.pop_back();
            r.last = 1'b1;
            awaited.push_back(r);
         end
      endfunction

      function void check_result(logic [2:0] kind, logic [30:0] value, logic [1:0] status,
                                 logic last);
         result_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: kind %0d value %0d status %0d last %0d",
                        kind, value, status, last);
            return;
         end
         want = awaited.pop_front();
         if (kind !== want.kind || value !== want.value || status !== want.status ||
             last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("result mismatch: expected kind %0d value %0d status %0d last %0d,",
                      want.kind, want.value, want.status, want.last);
               $display(" got kind %0d value %0d status %0d last %0d",
                        kind, value, status, last);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = ACT_START;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [30:0] rsp_value;
   logic [1:0]  rsp_status;
   logic        rsp_last;

   reply_scoreboard sb;
   rx_item_type     burst[$];
   logic [7:0]      body_q[$];
   bit              req_calm = 1'b0;
   bit              rsp_calm = 1'b0;
   int unsigned     cycles = 0;
   string           decoy_keys [6] = '{"onlin", "onlinee", "maxx", "ma", "descriptio",
                                       "Online"};

   status_reply_stream_parser #(.KEY_DEPTH(KEY_DEPTH)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_action  (req_action),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_kind    (rsp_kind),
      .rsp_value   (rsp_value),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // handshakes sampled with pre-edge values; input noted before output checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_item(req_action, req_rx_byte);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_kind, rsp_value, rsp_status, rsp_last);
      end
   end

   function automatic void queue_byte(logic act, logic [7:0] data);
      rx_item_type it;
      it.act = act;
      it.data = data;
      burst.push_back(it);
   endfunction

   function automatic void open_reply();
      queue_byte(ACT_START, 8'($urandom()));
      queue_byte(ACT_BYTE, 8'($urandom()));
   endfunction

   function automatic void push_varint(logic [31:0] v);
      while (v >= 32'h80) begin
         queue_byte(ACT_BYTE, {1'b1, v[6:0]});
         v = v >> 7;
      end
      queue_byte(ACT_BYTE, {1'b0, v[6:0]});
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
   endfunction

   function automatic void add_number();
      int         n;
      logic [7:0] t;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
      repeat (n) body_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      t = 8'($urandom_range(0, 255));
      if (t >= CHAR_ZERO && t <= CHAR_NINE) t = ",";
      body_q.push_back(t);
   endfunction

   function automatic void emit_body(logic [31:0] blen);
      queue_byte(ACT_BYTE, 8'($urandom()));
      push_varint(blen);
      foreach (body_q[i]) queue_byte(ACT_BYTE, body_q[i]);
      body_q.delete();
   endfunction

   task automatic send_item(logic act, logic [7:0] data);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_rx_byte <= data;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic send_burst();
      foreach (burst[i]) send_item(burst[i].act, burst[i].data);
      burst.delete();
   endtask

   initial begin
      int          stall;
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin
      int          mode, full;
      logic [31:0] blen;
      logic [7:0]  b;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      queue_byte(ACT_BYTE, 8'hFF);                       // byte while idle
      open_reply();
      push_varint(MIN_REPLY_LEN - 1);                    // just short
      open_reply();
      queue_byte(ACT_BYTE, 8'h00);                       // zero length byte
      open_reply();
      repeat (6) queue_byte(ACT_BYTE, 8'hFF);            // sixth group
      open_reply();
      push_varint(32'h8000_0000);                        // negative first length
      open_reply();
      push_varint(20);
      emit_body(0);                                      // empty body
      open_reply();
      push_varint(20);
      emit_body(32'hF000_0000);                          // negative body length
      open_reply();
      push_varint(20);                                   // dropped by next start
      open_reply();
      push_varint(MIN_REPLY_LEN);
      add_text("{\"description\":\"A");
      body_q.push_back(8'hFF);
      add_text("\",\"max\":99999999999,\"online\":,\"");
      repeat (KEY_DEPTH + 1) body_q.push_back("k");      // key wraps, then matches
      add_text("online\":007}");
      emit_body(body_q.size());
      open_reply();
      push_varint(16383);
      add_text("\"description\":\"x");
      body_q.push_back(8'h00);
      add_text("\"max\":12345,");
      emit_body(26);                                     // limit falls inside number
      send_burst();

      while (sb.parsed_items < ITEM_TARGET) begin
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 20))
               queue_byte(($urandom_range(0, 7) == 0) ? ACT_START : ACT_BYTE,
                          8'($urandom()));
         end else begin
            open_reply();
            mode = $urandom_range(0, 19);
            if (mode == 0) begin
               push_varint($urandom_range(0, 9));
            end else if (mode == 1) begin
               repeat ($urandom_range(1, 6)) queue_byte(ACT_BYTE, 8'($urandom_range(128, 255)));
            end else begin
               push_varint($urandom_range(10, 600));
               repeat ($urandom_range(1, 6)) begin
                  case ($urandom_range(0, 9))
                     0, 1: begin
                        add_text("\"online\":");
                        add_number();
                     end
                     2, 3: begin
                        add_text("\"max\":");
                        add_number();
                     end
                     4, 5: begin
                        add_text("\"description\":\"");
                        repeat ($urandom_range(0, 8)) begin
                           b = 8'($urandom_range(1, 255));
                           body_q.push_back(b == CHAR_QUOTE ? 8'h27 : b);
                        end
                        body_q.push_back($urandom_range(0, 3) == 0 ? 8'h00 : CHAR_QUOTE);
                     end
                     6: begin
                        body_q.push_back(CHAR_QUOTE);
                        add_text(decoy_keys[$urandom_range(0, 5)]);
                        add_text("\":1,");
                     end
                     7: begin
                        body_q.push_back(CHAR_QUOTE);
                        repeat (KEY_DEPTH + $urandom_range(0, 2)) body_q.push_back("k");
                        add_text("online\":");
                        add_number();
                     end
                     8: repeat ($urandom_range(1, 6)) body_q.push_back(8'($urandom()));
                     default: add_text($urandom_range(0, 1) ? "," : "{");
                  endcase
               end
               full = body_q.size();
               mode = $urandom_range(0, 99);
               if (mode < 78) blen = full;
               else if (mode < 86) blen = $urandom_range(1, full);
               else if (mode < 91) blen = full + $urandom_range(1, 4);
               else if (mode < 95) blen = 0;
               else blen = 32'h8000_0000 | $urandom();
               if ($urandom_range(0, 19) == 0)
                  repeat ($urandom_range(1, full)) void'(body_q.pop_back());
               emit_body(blen);
            end
         end
         send_burst();
      end

      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.awaited.size() != 0) begin
         sb.mismatches++;
         $display("%0d expected results never arrived", sb.awaited.size());
      end
      if (sb.mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
